// ----- rtl/core/tse_pkg.sv -----
// Shared types, character codes and tables for the template-to-script escaper.
package tse_pkg;

  localparam int unsigned HoldDepth  = 16;
  localparam int unsigned CharBits   = 16;
  localparam int unsigned SymW       = 16;
  localparam int unsigned HoldAddrW  = (HoldDepth > 1) ? $clog2(HoldDepth) : 1;
  localparam int unsigned HoldCntW   = $clog2(HoldDepth + 1);
  localparam int unsigned BraceW     = 16;
  localparam int unsigned PrefixLen  = 18;
  localparam int unsigned PrefixIdxW = $clog2(PrefixLen);

  typedef logic [CharBits-1:0] char_t;
  typedef logic [SymW-1:0]     sym_t;

  localparam char_t ChAt      = char_t'(8'h40);
  localparam char_t ChDollar  = char_t'(8'h24);
  localparam char_t ChLBrace  = char_t'(8'h7B);
  localparam char_t ChRBrace  = char_t'(8'h7D);
  localparam char_t ChLBrack  = char_t'(8'h5B);
  localparam char_t ChRBrack  = char_t'(8'h5D);
  localparam char_t ChNl      = char_t'(8'h0A);
  localparam char_t ChBslash  = char_t'(8'h5C);
  localparam char_t ChQuote   = char_t'(8'h22);
  localparam char_t ChApos    = char_t'(8'h27);

  localparam logic signed [BraceW-1:0] BraceMax  = {1'b0, {(BraceW-1){1'b1}}};
  localparam logic signed [BraceW-1:0] BraceMin  = {1'b1, {(BraceW-1){1'b0}}};
  localparam logic signed [BraceW-1:0] BraceOne  = BraceW'(1);

  // Emit plan bits, served lowest first
  localparam int unsigned EmAt  = 0;  // pending at-sign
  localparam int unsigned EmEsc = 1;  // backslash, dollar
  localparam int unsigned EmBs  = 2;  // backslash before the character
  localparam int unsigned EmChr = 3;  // the character itself
  localparam int unsigned EmPre = 4;  // append prefix
  localparam int unsigned EmCls = 5;  // quote, newline
  localparam int unsigned EmitW = 6;

  typedef logic [EmitW-1:0] emit_mask_t;

  typedef struct packed {
    logic load;
    logic rep_start;
    logic hold_drop;
    logic hold_wr;
    logic rd;
    logic plan;
    logic src_ram;
    logic tail;
    logic emit;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic skip_path;
    logic is_nl;
    logic can_hold;
    logic held_nz;
    logic rep_more;
    logic emit_done;
    logic pend_valid;
    logic can_push;
  } stat_t;

  function automatic logic is_blank(char_t c);
    logic [31:0] v;
    v = 32'(c);
    return (v >= 32'h09 && v <= 32'h0D) || v == 32'h20 || v == 32'hA0 ||
           v == 32'h1680 || (v >= 32'h2000 && v <= 32'h200A) ||
           v == 32'h2028 || v == 32'h2029 || v == 32'h202F ||
           v == 32'h205F || v == 32'h3000;
  endfunction

  function automatic logic is_special(char_t c);
    return c == ChBslash || c == ChLBrace || c == ChRBrace || c == ChLBrack ||
           c == ChRBrack || c == ChApos || c == ChQuote;
  endfunction

  function automatic char_t prefix_char(logic [PrefixIdxW-1:0] idx);
    char_t c;
    case (idx)
      PrefixIdxW'(0):  c = char_t'(8'h0A);
      PrefixIdxW'(1):  c = char_t'(8'h61);
      PrefixIdxW'(2):  c = char_t'(8'h70);
      PrefixIdxW'(3):  c = char_t'(8'h70);
      PrefixIdxW'(4):  c = char_t'(8'h65);
      PrefixIdxW'(5):  c = char_t'(8'h6E);
      PrefixIdxW'(6):  c = char_t'(8'h64);
      PrefixIdxW'(7):  c = char_t'(8'h20);
      PrefixIdxW'(8):  c = char_t'(8'h67);
      PrefixIdxW'(9):  c = char_t'(8'h32);
      PrefixIdxW'(10): c = char_t'(8'h72);
      PrefixIdxW'(11): c = char_t'(8'h65);
      PrefixIdxW'(12): c = char_t'(8'h73);
      PrefixIdxW'(13): c = char_t'(8'h75);
      PrefixIdxW'(14): c = char_t'(8'h6C);
      PrefixIdxW'(15): c = char_t'(8'h74);
      PrefixIdxW'(16): c = char_t'(8'h20);
      PrefixIdxW'(17): c = char_t'(8'h22);
      default:         c = '0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/tse_in_if.sv -----
// Input channel: one template character or an end-of-template marker.
interface tse_in_if;
  logic               valid;
  logic               ready;
  logic [tse_pkg::SymW-1:0] symbol;
  logic               finish;

  modport source (output valid, output symbol, output finish, input ready);
  modport sink   (input valid, input symbol, input finish, output ready);
endinterface

// ----- rtl/core/tse_out_if.sv -----
// Output channel: one script character with an end-of-run flag.
interface tse_out_if;
  logic               valid;
  logic               ready;
  logic [tse_pkg::SymW-1:0] out_symbol;
  logic               run_last;

  modport source (output valid, output out_symbol, output run_last, input ready);
  modport sink   (input valid, input out_symbol, input run_last, output ready);
endinterface

// ----- rtl/core/tse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tse_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tse_ctrl.sv -----
// Sequencing state machine: decides the path of each transaction and steps the datapath.
module tse_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tse_pkg::stat_t stat_i,
  output tse_pkg::cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StDecide = 7'b0000010,
    StRead   = 7'b0000100,
    StPlan   = 7'b0001000,
    StEmit   = 7'b0010000,
    StTail   = 7'b0100000,
    StFlush  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;
  logic   item_pend_q, item_pend_d;
  logic   src_ram_q, src_ram_d;

  always_comb begin
    state_d     = state_q;
    fin_d       = fin_q;
    item_pend_d = item_pend_q;
    src_ram_d   = src_ram_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDecide;
        end
      end
      StDecide: begin
        fin_d       = stat_i.fin;
        item_pend_d = 1'b0;
        src_ram_d   = 1'b0;
        if (stat_i.fin) begin
          cmd_o.rep_start = 1'b1;
          state_d = stat_i.held_nz ? StRead : StTail;
        end else if (stat_i.skip_path && stat_i.is_nl) begin
          cmd_o.hold_drop = 1'b1;
          state_d = StFlush;
        end else if (stat_i.skip_path && stat_i.can_hold) begin
          cmd_o.hold_wr = 1'b1;
          state_d = StFlush;
        end else if (stat_i.skip_path) begin
          // skip ends: replay what was held, then the character itself
          cmd_o.rep_start = 1'b1;
          if (stat_i.held_nz) begin
            item_pend_d = 1'b1;
            state_d     = StRead;
          end else begin
            state_d = StPlan;
          end
        end else begin
          state_d = StPlan;
        end
      end
      StRead: begin
        cmd_o.rd  = 1'b1;
        src_ram_d = 1'b1;
        state_d   = StPlan;
      end
      StPlan: begin
        cmd_o.plan    = 1'b1;
        cmd_o.src_ram = src_ram_q;
        state_d       = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (stat_i.emit_done) begin
          if (stat_i.rep_more) begin
            state_d = StRead;
          end else if (item_pend_q) begin
            item_pend_d = 1'b0;
            src_ram_d   = 1'b0;
            state_d     = StPlan;
          end else if (fin_q) begin
            state_d = StTail;
          end else begin
            state_d = StFlush;
          end
        end
      end
      StTail: begin
        cmd_o.tail = 1'b1;
        fin_d      = 1'b0;
        state_d    = StEmit;
      end
      StFlush: begin
        cmd_o.flush = 1'b1;
        if (!stat_i.pend_valid || stat_i.can_push) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fin_q       <= 1'b0;
      item_pend_q <= 1'b0;
      src_ram_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      item_pend_q <= item_pend_d;
      src_ram_q   <= src_ram_d;
    end
  end

endmodule

// ----- rtl/core/tse_dp.sv -----
// Datapath: mode flags, held-blank store, emit planner and the output register.
module tse_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tse_pkg::cmd_t        cmd_i,
  output tse_pkg::stat_t       stat_o,
  input  tse_pkg::sym_t        in_symbol_i,
  input  logic                 in_finish_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output tse_pkg::sym_t        out_symbol_o,
  output logic                 out_last_o
);

  localparam int unsigned HoldCntW   = tse_pkg::HoldCntW;
  localparam int unsigned HoldAddrW  = tse_pkg::HoldAddrW;
  localparam int unsigned PrefixIdxW = tse_pkg::PrefixIdxW;
  localparam int unsigned BraceW     = tse_pkg::BraceW;

  // item and mode state
  tse_pkg::char_t item_sym_q, item_sym_d;
  logic           item_fin_q, item_fin_d;
  logic           at_q, at_d, copy_q, copy_d, dol_q, dol_d;
  logic           var_q, var_d, skip_q, skip_d;
  logic signed [BraceW-1:0] brace_q, brace_d;
  logic [HoldCntW-1:0] held_cnt_q, held_cnt_d;
  logic [HoldCntW-1:0] rep_n_q, rep_n_d, rep_k_q, rep_k_d;

  // emit plan
  tse_pkg::emit_mask_t    mask_q, mask_d;
  logic [PrefixIdxW-1:0]  sub_q, sub_d;
  tse_pkg::char_t         plan_sym_q, plan_sym_d;

  // pending character and output register
  logic           pend_valid_q, pend_valid_d;
  tse_pkg::sym_t  pend_sym_q, pend_sym_d;
  logic           out_valid_q, out_valid_d;
  tse_pkg::sym_t  out_sym_q, out_sym_d;
  logic           out_last_q, out_last_d;

  tse_pkg::char_t ram_rdata;
  tse_pkg::char_t pc;
  logic           can_push;

  // planner results
  tse_pkg::emit_mask_t plan_mask;
  logic           p_at, p_copy, p_dol, p_var, p_skip;
  logic signed [BraceW-1:0] p_brace;

  // emit step results
  logic                  emit_fire;
  tse_pkg::char_t        emit_ch;
  tse_pkg::emit_mask_t   emit_mask;
  logic [PrefixIdxW-1:0] emit_sub;

  tse_ram #(
    .Width (tse_pkg::CharBits),
    .Depth (tse_pkg::HoldDepth)
  ) u_hold (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hold_wr),
    .waddr_i (held_cnt_q[HoldAddrW-1:0]),
    .wdata_i (item_sym_q),
    .re_i    (cmd_i.rd),
    .raddr_i (rep_k_q[HoldAddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign can_push = !out_valid_q || out_ready_i;
  assign pc       = cmd_i.src_ram ? ram_rdata : item_sym_q;

  assign stat_o.fin        = item_fin_q;
  assign stat_o.skip_path  = skip_q && !(held_cnt_q == '0 && item_sym_q == tse_pkg::ChAt);
  assign stat_o.is_nl      = item_sym_q == tse_pkg::ChNl;
  assign stat_o.can_hold   = tse_pkg::is_blank(item_sym_q) &&
                             (held_cnt_q < HoldCntW'(tse_pkg::HoldDepth));
  assign stat_o.held_nz    = held_cnt_q != '0;
  assign stat_o.rep_more   = rep_k_q < rep_n_q;
  assign stat_o.emit_done  = mask_q == '0;
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.can_push   = can_push;

  // What one character emits and how it moves the mode flags
  always_comb begin
    plan_mask = '0;
    p_at      = at_q;
    p_copy    = copy_q;
    p_dol     = dol_q;
    p_var     = var_q;
    p_skip    = skip_q;
    p_brace   = brace_q;
    if (pc == tse_pkg::ChAt) begin
      if (at_q) begin
        if (copy_q) begin
          plan_mask[tse_pkg::EmPre] = 1'b1;
        end else begin
          plan_mask[tse_pkg::EmCls] = 1'b1;
        end
        p_copy = !copy_q;
        p_skip = 1'b1;
      end
      p_at = !at_q;
    end else begin
      plan_mask[tse_pkg::EmAt] = at_q;
      p_at = 1'b0;
      if (copy_q) begin
        plan_mask[tse_pkg::EmChr] = 1'b1;
      end else if (pc == tse_pkg::ChDollar) begin
        if (dol_q) begin
          p_var   = 1'b1;
          p_brace = '0;
          plan_mask[tse_pkg::EmChr] = 1'b1;
        end
        p_dol = !dol_q;
      end else begin
        plan_mask[tse_pkg::EmEsc] = dol_q;
        p_dol = 1'b0;
        if (var_q) begin
          plan_mask[tse_pkg::EmChr] = 1'b1;
          if (pc == tse_pkg::ChLBrace && brace_q != tse_pkg::BraceMax) begin
            p_brace = brace_q + tse_pkg::BraceOne;
          end else if (pc == tse_pkg::ChRBrace && brace_q != tse_pkg::BraceMin) begin
            p_brace = brace_q - tse_pkg::BraceOne;
          end
          p_var = p_brace != '0;
        end else begin
          plan_mask[tse_pkg::EmBs]  = tse_pkg::is_special(pc);
          plan_mask[tse_pkg::EmChr] = 1'b1;
        end
      end
    end
  end

  // One character per step, lowest plan bit first
  always_comb begin
    emit_ch   = tse_pkg::ChAt;
    emit_mask = mask_q;
    emit_sub  = sub_q + PrefixIdxW'(1);
    if (mask_q[tse_pkg::EmAt]) begin
      emit_ch   = tse_pkg::ChAt;
      emit_mask[tse_pkg::EmAt] = 1'b0;
      emit_sub  = '0;
    end else if (mask_q[tse_pkg::EmEsc]) begin
      if (sub_q == '0) begin
        emit_ch = tse_pkg::ChBslash;
      end else begin
        emit_ch  = tse_pkg::ChDollar;
        emit_mask[tse_pkg::EmEsc] = 1'b0;
        emit_sub = '0;
      end
    end else if (mask_q[tse_pkg::EmBs]) begin
      emit_ch  = tse_pkg::ChBslash;
      emit_mask[tse_pkg::EmBs] = 1'b0;
      emit_sub = '0;
    end else if (mask_q[tse_pkg::EmChr]) begin
      emit_ch  = plan_sym_q;
      emit_mask[tse_pkg::EmChr] = 1'b0;
      emit_sub = '0;
    end else if (mask_q[tse_pkg::EmPre]) begin
      emit_ch = tse_pkg::prefix_char(sub_q);
      if (sub_q == PrefixIdxW'(tse_pkg::PrefixLen - 1)) begin
        emit_mask[tse_pkg::EmPre] = 1'b0;
        emit_sub = '0;
      end
    end else if (mask_q[tse_pkg::EmCls]) begin
      if (sub_q == '0) begin
        emit_ch = tse_pkg::ChQuote;
      end else begin
        emit_ch  = tse_pkg::ChNl;
        emit_mask[tse_pkg::EmCls] = 1'b0;
        emit_sub = '0;
      end
    end
  end

  assign emit_fire = cmd_i.emit && (mask_q != '0) && can_push;

  always_comb begin
    item_sym_d   = item_sym_q;
    item_fin_d   = item_fin_q;
    at_d         = at_q;
    copy_d       = copy_q;
    dol_d        = dol_q;
    var_d        = var_q;
    skip_d       = skip_q;
    brace_d      = brace_q;
    held_cnt_d   = held_cnt_q;
    rep_n_d      = rep_n_q;
    rep_k_d      = rep_k_q;
    mask_d       = mask_q;
    sub_d        = sub_q;
    plan_sym_d   = plan_sym_q;
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_sym_d    = out_sym_q;
    out_last_d   = out_last_q;

    if (cmd_i.load) begin
      item_sym_d = tse_pkg::char_t'(in_symbol_i);
      item_fin_d = in_finish_i;
    end
    if (cmd_i.rep_start) begin
      rep_n_d    = held_cnt_q;
      rep_k_d    = '0;
      held_cnt_d = '0;
      skip_d     = 1'b0;
    end
    if (cmd_i.hold_drop) begin
      held_cnt_d = '0;
      skip_d     = 1'b0;
    end
    if (cmd_i.hold_wr) begin
      held_cnt_d = held_cnt_q + HoldCntW'(1);
    end
    if (cmd_i.plan) begin
      at_d       = p_at;
      copy_d     = p_copy;
      dol_d      = p_dol;
      var_d      = p_var;
      skip_d     = p_skip;
      brace_d    = p_brace;
      mask_d     = plan_mask;
      sub_d      = '0;
      plan_sym_d = pc;
      if (cmd_i.src_ram) begin
        rep_k_d = rep_k_q + HoldCntW'(1);
      end
    end
    if (cmd_i.tail) begin
      // trailing at-sign, dollar and close, then back to the reset state
      mask_d = '0;
      mask_d[tse_pkg::EmAt]  = at_q;
      mask_d[tse_pkg::EmEsc] = dol_q;
      mask_d[tse_pkg::EmCls] = !copy_q;
      sub_d      = '0;
      at_d       = 1'b0;
      copy_d     = 1'b1;
      dol_d      = 1'b0;
      var_d      = 1'b0;
      skip_d     = 1'b0;
      brace_d    = '0;
      held_cnt_d = '0;
    end
    // one character stays pending so the last one of a run can be marked
    if (emit_fire) begin
      mask_d = emit_mask;
      sub_d  = emit_sub;
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_sym_d   = pend_sym_q;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_sym_d   = tse_pkg::SymW'(emit_ch);
    end
    if (cmd_i.flush && pend_valid_q && can_push) begin
      out_valid_d  = 1'b1;
      out_sym_d    = pend_sym_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_q         <= 1'b0;
      copy_q       <= 1'b1;
      dol_q        <= 1'b0;
      var_q        <= 1'b0;
      skip_q       <= 1'b0;
      brace_q      <= '0;
      held_cnt_q   <= '0;
      rep_n_q      <= '0;
      rep_k_q      <= '0;
      mask_q       <= '0;
      sub_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      at_q         <= at_d;
      copy_q       <= copy_d;
      dol_q        <= dol_d;
      var_q        <= var_d;
      skip_q       <= skip_d;
      brace_q      <= brace_d;
      held_cnt_q   <= held_cnt_d;
      rep_n_q      <= rep_n_d;
      rep_k_q      <= rep_k_d;
      mask_q       <= mask_d;
      sub_q        <= sub_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_sym_q <= item_sym_d;
    item_fin_q <= item_fin_d;
    plan_sym_q <= plan_sym_d;
    pend_sym_q <= pend_sym_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_symbol_o = out_sym_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- rtl/core/template_to_script_escaper_unit.sv -----
// Top level of the template-to-script escaper: controller plus datapath.
//
// Usage: feed template characters on in_i (symbol, finish) with valid/ready;
// script characters come out on out_o (out_symbol, run_last) with valid/ready.
// Each input transaction yields zero or more output transactions; run_last
// marks the final one caused by that input. finish=1 flushes held blanks,
// trailing at/dollar and an open text run, then returns to the reset state.
// Timing: one input at a time. A plain character passes the decide, plan,
// emit and flush steps; a held blank only decide and flush; each replayed
// blank is read from the store, planned and emitted before the character.
// The pace is set by the single emit step of the sequencer, one character
// a cycle while the receiver is not stalling.
// Results are registered: out_o is driven from a flop, and the next input is
// taken while the final result of the previous one still waits in it.
// Reset (rst_ni low, asynchronous) clears all mode flags, the hold count and
// the output register; the blank store needs no clearing.
// A stalled receiver (out_o.ready low) freezes the emit step; nothing is lost.
module template_to_script_escaper_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  tse_in_if.sink    in_i,
  tse_out_if.source out_o
);

  tse_pkg::cmd_t  cmd;
  tse_pkg::stat_t stat;

  tse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tse_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_symbol_i  (in_i.symbol),
    .in_finish_i  (in_i.finish),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_symbol_o (out_o.out_symbol),
    .out_last_o   (out_o.run_last)
  );

endmodule

// ----- rtl/core/tse_chk.sv -----
// Port-level checker for the escaper, bound to the top level.
module tse_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input tse_pkg::sym_t out_symbol_i,
  input logic          out_last_i
);

  // a stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_symbol_i) && $stable(out_last_i))
    else $error("output transaction changed while stalled");

  // one input at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken in the cycle after a transaction");

  // a run is open until its last character is shown
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input ready while a run is incomplete");

endmodule

bind template_to_script_escaper_unit tse_chk u_tse_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_symbol_i (out_o.out_symbol),
  .out_last_i   (out_o.run_last)
);
